>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with reset disable, removable by NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> sv/otcd_pkg.sv
// ----------------------------------------------------------------------------
// otcd_pkg
// Shared constants and codes of the oscillator compensation block.
// ----------------------------------------------------------------------------
`default_nettype none
package otcd_pkg;

  typedef enum logic [1:0] {
    FN_SAMPLE = 2'd0,
    FN_CURVE  = 2'd1,
    FN_CORR   = 2'd2,
    FN_ABORT  = 2'd3
  } func_e;

  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_TBL_LO    = 3'd1;
  localparam logic [2:0] REG_TBL_HI    = 3'd2;
  localparam logic [2:0] REG_SMOOTH_LO = 3'd3;
  localparam logic [2:0] REG_SMOOTH_HI = 3'd4;
  localparam logic [2:0] REG_GAIN      = 3'd5;
  localparam logic [2:0] REG_OFFSET    = 3'd6;
  localparam logic [2:0] REG_CORR_EN   = 3'd7;

  localparam logic [3:0]  WORK_FRAME      = 4'd10;
  localparam logic [3:0]  PULL_TEMP_FRAME = 4'd8;
  localparam logic [15:0] INVALID_MARK    = 16'hFFFF;
  localparam logic [11:0] DAC_MIN         = 12'd2;
  localparam logic [11:0] DAC_MAX         = 12'd4095;
  localparam logic signed [16:0] SLEW_LIMIT = 17'sd5;
  localparam logic signed [16:0] CORR_BIAS  = 17'sd1024;
  localparam logic signed [12:0] PULL_BIAS  = 13'sd2048;
  // floor(x / 5) = (x * DIV5_MUL) >> DIV5_SHIFT for x below 2**19
  localparam logic [18:0] DIV5_MUL   = 19'd419431;
  localparam int          DIV5_SHIFT = 21;

endpackage
`default_nettype wire

>>> sv/otcd_ram.sv
// ----------------------------------------------------------------------------
// otcd_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module otcd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> sv/oscillator_temp_compensation_dac.sv
// ----------------------------------------------------------------------------
// oscillator_temp_compensation_dac
// Frame-based temperature compensation driving a 12-bit DAC code.
// ----------------------------------------------------------------------------
// Input channel (valid/ready): one transfer carries a sample, a curve or
// correction table write, or a frame abort. Table writes and samples that do
// not finish a frame leave the block idle, so it stays ready for the next.
// The sample that finishes a frame starts the finishing pass: odd-even
// transposition sorting on the sample registers (pull mode only; work mode
// skips the sort), then averaging, history smoothing in pull mode, table
// read from the curve and correction RAMs (registered read), scaling
// multiply and saturation, after which the result is loaded.
// Output channel (valid/ready): one transfer per finished frame, held in an
// output register; input transfers continue while it waits. If the receiver
// still stalls when the next frame finishes, the block holds in its last
// step until the register frees.
// Configuration: plain write port, to be written by the user only while idle;
// not enforced by the block. Writing the mode register restarts the frame.
// Reset clears counts, history, slew state and registers; the tables and
// sample registers are undefined until written. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module oscillator_temp_compensation_dac
  import otcd_pkg::*;
#(
  parameter int TABLE_DEPTH = 2048,
  parameter int PULL_COUNT  = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [1:0]         func_i,
  input  wire logic               channel_i,
  input  wire logic [11:0]        sample_i,
  input  wire logic [10:0]        table_index_i,
  input  wire logic signed [15:0] table_value_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic [11:0]        dac_code_o,
  output      logic               in_table_range_o,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i
);
  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int PCW = $clog2(PULL_COUNT + 1);
  localparam int PIW = $clog2(PULL_COUNT);
  localparam int MID = PULL_COUNT / 2;
  localparam logic [12:0] DEPTH13 = 13'(TABLE_DEPTH);
  localparam logic [PCW-1:0] PULL_FULL = PCW'(PULL_COUNT);
  localparam logic [PCW-1:0] PASS_LAST = PCW'(PULL_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SORT, ST_AVG, ST_HIST, ST_LOOK, ST_CALC, ST_MUL, ST_OUT
  } state_e;

  // configuration
  logic               mode_q, corr_en_q;
  logic [11:0]        tbl_lo_q, tbl_hi_q, sm_lo_q, sm_hi_q;
  logic signed [15:0] gain_q, offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      tbl_lo_q  <= 12'd0;
      tbl_hi_q  <= 12'd4095;
      sm_lo_q   <= 12'd0;
      sm_hi_q   <= 12'd4095;
      gain_q    <= 16'sd4096;
      offset_q  <= 16'sd0;
      corr_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODE:      mode_q    <= cfg_data_i[0];
        REG_TBL_LO:    tbl_lo_q  <= cfg_data_i[11:0];
        REG_TBL_HI:    tbl_hi_q  <= cfg_data_i[11:0];
        REG_SMOOTH_LO: sm_lo_q   <= cfg_data_i[11:0];
        REG_SMOOTH_HI: sm_hi_q   <= cfg_data_i[11:0];
        REG_GAIN:      gain_q    <= cfg_data_i;
        REG_OFFSET:    offset_q  <= cfg_data_i;
        REG_CORR_EN:   corr_en_q <= cfg_data_i[0];
        default:       ;
      endcase
    end
  end

  // handshake and decode
  state_e         state_q;
  logic           acc;
  func_e          fn;
  logic [3:0]     tcnt_q;
  logic [PCW-1:0] pcnt_q, pass_q;
  logic           take_t, take_p, frame_done;
  logic [3:0]     tcnt_nx;
  logic [PCW-1:0] pcnt_nx;

  assign in_ready_o = (state_q == ST_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign fn         = func_e'(func_i);

  always_comb begin
    take_t = 1'b0;
    take_p = 1'b0;
    if (acc && fn == FN_SAMPLE) begin
      if (!mode_q) begin
        take_t = !channel_i && (tcnt_q < WORK_FRAME);
      end else if (!channel_i) begin
        take_t = tcnt_q < PULL_TEMP_FRAME;
      end else begin
        take_p = pcnt_q < PULL_FULL;
      end
    end
    tcnt_nx = tcnt_q + 4'(take_t);
    pcnt_nx = pcnt_q + PCW'(take_p);
    if (!mode_q) begin
      frame_done = take_t && (tcnt_nx >= WORK_FRAME);
    end else begin
      frame_done = acc && fn == FN_SAMPLE && (tcnt_nx >= PULL_TEMP_FRAME)
                   && (pcnt_nx >= PULL_FULL);
    end
  end

  // sample registers with odd-even transposition sort
  logic [11:0] ts_q [10];
  logic [11:0] ps_q [PULL_COUNT];
  logic [11:0] ts_s [10];
  logic [11:0] ps_s [PULL_COUNT];

  always_comb begin
    ts_s = ts_q;
    ps_s = ps_q;
    for (int i = 0; i < 7; i++) begin
      if (((i & 1) == int'(pass_q[0])) && ts_q[i] > ts_q[i+1]) begin
        ts_s[i]   = ts_q[i+1];
        ts_s[i+1] = ts_q[i];
      end
    end
    for (int i = 0; i < PULL_COUNT - 1; i++) begin
      if (((i & 1) == int'(pass_q[0])) && ps_q[i] > ps_q[i+1]) begin
        ps_s[i]   = ps_q[i+1];
        ps_s[i+1] = ps_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SORT) begin
      ts_q <= ts_s;
      ps_q <= ps_s;
    end else begin
      if (take_t) begin
        ts_q[tcnt_q] <= sample_i;
      end
      if (take_p) begin
        ps_q[pcnt_q[PIW-1:0]] <= sample_i;
      end
    end
  end

  // tables
  logic          tbl_ok, we_curve, we_corr;
  logic [11:0]   lk_idx;
  logic          lk_in;
  logic [15:0]   curve_rd, corr_rd;

  assign tbl_ok   = {2'b00, table_index_i} < DEPTH13;
  assign we_curve = acc && fn == FN_CURVE && tbl_ok;
  assign we_corr  = acc && fn == FN_CORR && tbl_ok;

  otcd_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_curve (
    .clk_i   (clk_i),
    .we_i    (we_curve),
    .waddr_i (AW'(table_index_i)),
    .wdata_i (table_value_i),
    .raddr_i (lk_idx[AW-1:0]),
    .rdata_o (curve_rd)
  );

  otcd_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_corr (
    .clk_i   (clk_i),
    .we_i    (we_corr),
    .waddr_i (AW'(table_index_i)),
    .wdata_i (table_value_i),
    .raddr_i (lk_idx[AW-1:0]),
    .rdata_o (corr_rd)
  );

  // datapath
  logic [15:0]        hist_q [4];
  logic [18:0]        sum_q;
  logic               use_div_q;
  logic [11:0]        t_q, s_q;
  logic               hit_q, lk_in_q;
  logic signed [15:0] last_q;
  logic signed [17:0] y_q;
  logic signed [33:0] prod_q;
  logic               dac_vld_q, dac_hit_q;
  logic [11:0]        dac_q;

  logic [13:0] tsum, psum;
  logic [18:0] hsum;
  logic [37:0] div_prod;
  logic [11:0] t_new;
  logic        hit_c;
  logic signed [15:0] curve_v, corr_v, c_sel;
  logic signed [16:0] dlt;
  logic signed [17:0] y_c;
  logic signed [21:0] q_tr;
  logic signed [22:0] q_off;
  logic [11:0]        code_c;

  always_comb begin
    if (mode_q) begin
      tsum = 14'(ts_q[2]) + 14'(ts_q[3]) + 14'(ts_q[4]) + 14'(ts_q[5]);
    end else begin
      tsum = 14'(ts_q[4]) + 14'(ts_q[5]) + 14'(ts_q[6]) + 14'(ts_q[7]);
    end
    psum = 14'(ps_q[MID]) + 14'(ps_q[MID+1]) + 14'(ps_q[MID+2]) + 14'(ps_q[MID+3]);
    hsum = 19'(hist_q[0]) + 19'(hist_q[1]) + 19'(hist_q[2]) + 19'(hist_q[3]);
    div_prod = 38'(sum_q) * 38'(DIV5_MUL);
    t_new = use_div_q ? div_prod[DIV5_SHIFT+11:DIV5_SHIFT] : sum_q[11:0];

    hit_c  = (t_q < tbl_hi_q) && (t_q > tbl_lo_q);
    lk_idx = t_q - tbl_lo_q;
    lk_in  = {1'b0, lk_idx} < DEPTH13;

    curve_v = lk_in_q ? $signed(curve_rd) : 16'sd0;
    corr_v  = lk_in_q ? $signed(corr_rd) : 16'sd0;
    dlt     = 17'(corr_v) - 17'(last_q);
    c_sel   = (dlt > SLEW_LIMIT || dlt < -SLEW_LIMIT) ? last_q : corr_v;
    y_c     = 18'sd0;
    if (hit_q) begin
      y_c = 18'(curve_v);
      if (corr_en_q) begin
        y_c = y_c + 18'(17'(c_sel) - CORR_BIAS);
      end
    end
    if (mode_q) begin
      y_c = y_c + 18'($signed({1'b0, s_q}) - PULL_BIAS);
    end

    q_tr = prod_q[33:12];
    if (prod_q[33] && (prod_q[11:0] != 12'd0)) begin
      q_tr = q_tr + 22'sd1;
    end
    q_off = 23'(q_tr) + 23'(offset_q);
    if (q_off < 23'(signed'({1'b0, DAC_MIN}))) begin
      code_c = DAC_MIN;
    end else if (q_off > 23'(signed'({1'b0, DAC_MAX}))) begin
      code_c = DAC_MAX;
    end else begin
      code_c = q_off[11:0];
    end
    if (!mode_q && !hit_q) begin
      code_c = DAC_MIN;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_AVG: begin
        use_div_q <= mode_q && (hist_q[0] != INVALID_MARK);
        sum_q     <= (mode_q && hist_q[0] != INVALID_MARK) ?
                     19'(tsum[13:2]) + hsum : 19'(tsum[13:2]);
        s_q       <= psum[13:2];
      end
      ST_HIST: t_q <= t_new;
      ST_LOOK: begin
        hit_q   <= hit_c;
        lk_in_q <= lk_in;
      end
      ST_CALC: y_q <= y_c;
      ST_MUL:  prod_q <= 34'(gain_q) * 34'(y_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      tcnt_q    <= 4'd0;
      pcnt_q    <= '0;
      pass_q    <= '0;
      hist_q    <= '{default: INVALID_MARK};
      last_q    <= 16'sd0;
      dac_vld_q <= 1'b0;
      dac_hit_q <= 1'b0;
      dac_q     <= DAC_MIN;
    end else begin
      if (dac_vld_q && out_ready_i && state_q != ST_OUT) begin
        dac_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cfg_we_i && cfg_index_i == REG_MODE) begin
            tcnt_q <= 4'd0;
            pcnt_q <= '0;
          end else if (acc && fn == FN_ABORT) begin
            tcnt_q <= 4'd0;
            pcnt_q <= '0;
          end else if (frame_done) begin
            tcnt_q  <= 4'd0;
            pcnt_q  <= '0;
            pass_q  <= '0;
            state_q <= mode_q ? ST_SORT : ST_AVG;
          end else begin
            tcnt_q <= tcnt_nx;
            pcnt_q <= pcnt_nx;
          end
        end
        ST_SORT: begin
          pass_q <= pass_q + PCW'(1);
          if (pass_q == PASS_LAST) begin
            state_q <= ST_AVG;
          end
        end
        ST_AVG:  state_q <= ST_HIST;
        ST_HIST: begin
          if (mode_q) begin
            if (t_new < sm_hi_q && t_new > sm_lo_q) begin
              hist_q[0] <= hist_q[1];
              hist_q[1] <= hist_q[2];
              hist_q[2] <= hist_q[3];
              hist_q[3] <= 16'(t_new);
            end else begin
              hist_q[0] <= INVALID_MARK;
            end
          end
          state_q <= ST_LOOK;
        end
        ST_LOOK: state_q <= ST_CALC;
        ST_CALC: begin
          if (hit_q && corr_en_q) begin
            last_q <= c_sel;
          end
          state_q <= ST_MUL;
        end
        ST_MUL: state_q <= ST_OUT;
        ST_OUT: begin
          if (!dac_vld_q || out_ready_i) begin
            dac_vld_q <= 1'b1;
            dac_q     <= code_c;
            dac_hit_q <= hit_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o      = dac_vld_q;
  assign dac_code_o       = dac_q;
  assign in_table_range_o = dac_hit_q;

  `ASSERT_CLK(a_code_range, clk_i, rst_ni, out_valid_o |-> (dac_code_o >= DAC_MIN))
  `ASSERT_CLK(a_tcnt_bound, clk_i, rst_ni, tcnt_q <= WORK_FRAME)
  `ASSERT_CLK(a_load_free, clk_i, rst_ni, (state_q == ST_OUT && dac_vld_q && !out_ready_i) |=> (state_q == ST_OUT))
  `ASSERT_NEVER(a_busy_ready, clk_i, rst_ni, in_ready_o && state_q != ST_IDLE)
endmodule
`default_nettype wire
